// ===== rtl/core/iah_pkg.sv =====
// iah_pkg: shared types and constants of the i/o alignment histogram block
// no dependencies; imported by every module of the block but iah_ram

package iah_pkg;

   // fixed field widths of the channels
   localparam int KIND_W   = 2;
   localparam int DISK_W   = 3;
   localparam int LEN_W    = 32;
   localparam int SECTOR_W = 48;
   localparam int SHIFT_W  = 5;
   localparam int BIN_W    = 10;
   localparam int EXP_W    = 5;
   localparam int COUNT_W  = 32;

   // log2 of the 512-byte sector
   localparam int SECTOR_EXP = 9;

   // default sizes of the histograms
   localparam int DEF_NUM_DISKS  = 8;
   localparam int DEF_GRAN_BINS  = 1024;
   localparam int DEF_ALIGN_BINS = 32;

   // widest indexes over the allowed parameter range
   localparam int DIDX_MAX_W = 6;
   localparam int GBIN_MAX_W = 13;
   localparam int ABIN_MAX_W = 6;

   // depth of the queue between front and back
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [KIND_W-1:0] {
      OP_RECORD = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   // classified item handed from front to back
   typedef struct packed {
      op_type                  op;
      logic                    hit;      // record: counted, read and clear: disk in range
      logic                    cell_ok;  // read and clear: bin in range
      logic                    hsel;
      logic [DIDX_MAX_W-1:0]   disk_idx;
      logic [GBIN_MAX_W-1:0]   gbin;
      logic [ABIN_MAX_W-1:0]   abin;
      logic [EXP_W-1:0]        aexp;
      logic [SHIFT_W-1:0]      shift;
   } cmd_type;

   typedef enum logic [1:0] {
      BK_CLEAR,
      BK_IDLE,
      BK_EXEC
   } back_state_type;

endpackage

// ===== rtl/core/io_alignment_histogram_top.sv =====
// io_alignment_histogram_top: per-disk i/o granularity and alignment histograms
// depends on iah_pkg, iah_front, iah_queue, iah_back (and iah_ram below it)
//
//  channel  | direction | handshake            | item
//  ---------+-----------+----------------------+------------------------------------------
//  req_     | in        | req_valid/req_ready  | kind, disk, length, sector, shift, sel, bin
//  rsp_     | out       | rsp_valid/rsp_ready  | counted, exps, bins, count, recorded shift
//  csr_     | in        | csr_valid/csr_ready  | align_filter write data
//
// flow: front classifies an item in the cycle it is accepted; back reads the counters, then
//   writes back and loads the result, and takes no new item until the last is written back
// reset: a clearing pass zeroes the counter memories, one address a cycle, over every
//   address of the largest memory; req_ready stays low meanwhile, csr writes are taken
// stalls: a 2-entry queue parts front and back; a result waits in the output register
//   while the next item is read, and the back holds its write-back until rsp is free

module io_alignment_histogram_top
   import iah_pkg::*;
#(
   parameter int NUM_DISKS  = DEF_NUM_DISKS,
   parameter int GRAN_BINS  = DEF_GRAN_BINS,
   parameter int ALIGN_BINS = DEF_ALIGN_BINS
) (
   input  logic                clock,
   input  logic                reset,

   // configuration write
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [LEN_W-1:0]    csr_align_filter,

   // request items
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [DISK_W-1:0]   req_disk,
   input  logic [LEN_W-1:0]    req_length,
   input  logic [SECTOR_W-1:0] req_sector,
   input  logic [SHIFT_W-1:0]  req_block_shift,
   input  logic                req_histogram_select,
   input  logic [BIN_W-1:0]    req_bin,

   // result items
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_counted,
   output logic [EXP_W-1:0]    rsp_alignment_exp,
   output logic [BIN_W-1:0]    rsp_gran_bin,
   output logic [EXP_W-1:0]    rsp_align_bin,
   output logic [COUNT_W-1:0]  rsp_count,
   output logic [SHIFT_W-1:0]  rsp_recorded_shift
);

   // classified item path between front and back
   cmd_type push_cmd;
   cmd_type head_cmd;
   logic    q_push, q_pop, q_empty, q_full;
   logic    clearing;

   // the filter register is always free to take a write
   assign csr_ready = 1'b1;

   // front: filter register, alignment and bin computation, range checks
   iah_front #(
      .NUM_DISKS  (NUM_DISKS),
      .GRAN_BINS  (GRAN_BINS),
      .ALIGN_BINS (ALIGN_BINS)
   ) u_front (
      .clock                (clock),
      .reset                (reset),
      .csr_valid            (csr_valid),
      .csr_align_filter     (csr_align_filter),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_kind             (req_kind),
      .req_disk             (req_disk),
      .req_length           (req_length),
      .req_sector           (req_sector),
      .req_block_shift      (req_block_shift),
      .req_histogram_select (req_histogram_select),
      .req_bin              (req_bin),
      .q_full               (q_full),
      .clearing             (clearing),
      .q_push               (q_push),
      .q_cmd                (push_cmd)
   );

   // short queue so front and back stall independently
   iah_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (push_cmd),
      .pop      (q_pop),
      .head     (head_cmd),
      .empty    (q_empty),
      .full     (q_full)
   );

   // back: counter memories, read-modify-write and result register
   iah_back #(
      .NUM_DISKS  (NUM_DISKS),
      .GRAN_BINS  (GRAN_BINS),
      .ALIGN_BINS (ALIGN_BINS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .q_head             (head_cmd),
      .q_empty            (q_empty),
      .q_pop              (q_pop),
      .clearing           (clearing),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_counted        (rsp_counted),
      .rsp_alignment_exp  (rsp_alignment_exp),
      .rsp_gran_bin       (rsp_gran_bin),
      .rsp_align_bin      (rsp_align_bin),
      .rsp_count          (rsp_count),
      .rsp_recorded_shift (rsp_recorded_shift)
   );

endmodule

// ===== rtl/core/iah_ram.sv =====
// iah_ram: generic single-write, single-read ram with registered read data
// no dependencies

module iah_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/iah_front.sv =====
// iah_front: filter register and item classification (alignment, bins, range checks)
// depends on iah_pkg

module iah_front
   import iah_pkg::*;
#(
   parameter int NUM_DISKS  = DEF_NUM_DISKS,
   parameter int GRAN_BINS  = DEF_GRAN_BINS,
   parameter int ALIGN_BINS = DEF_ALIGN_BINS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   input  logic [LEN_W-1:0]    csr_align_filter,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [DISK_W-1:0]   req_disk,
   input  logic [LEN_W-1:0]    req_length,
   input  logic [SECTOR_W-1:0] req_sector,
   input  logic [SHIFT_W-1:0]  req_block_shift,
   input  logic                req_histogram_select,
   input  logic [BIN_W-1:0]    req_bin,
   input  logic                q_full,
   input  logic                clearing,
   output logic                q_push,
   output cmd_type             q_cmd
);

   localparam int UP_W = LEN_W - SECTOR_EXP;

   logic [LEN_W-1:0] align_filter_ff;
   logic [LEN_W-1:0] align_filter_in;

   op_type              op;
   logic                disk_ok;
   logic                short_len;
   logic [LEN_W-1:0]    merged;
   logic [UP_W-1:0]     upper;
   logic [UP_W-1:0]     lowest;
   logic [EXP_W-1:0]    low_pos;
   logic [EXP_W-1:0]    aexp;
   logic [LEN_W-1:0]    align_val;
   logic                pass;
   logic [LEN_W-1:0]    gran_raw;
   logic [GBIN_MAX_W-1:0] gbin_rec;
   logic [ABIN_MAX_W-1:0] abin_rec;
   logic                cell_ok;

   assign align_filter_in = csr_valid ? csr_align_filter : align_filter_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         align_filter_ff <= '0;
      end else begin
         align_filter_ff <= align_filter_in;
      end
   end

   assign op      = op_type'(req_kind);
   assign disk_ok = 32'(req_disk) < 32'(NUM_DISKS);

   // alignment exponent: lowest set bit of length or byte offset, floor at 512
   assign short_len = (req_length[LEN_W-1:SECTOR_EXP] == '0);
   assign merged    = req_length | {req_sector[UP_W-1:0], SECTOR_EXP'(0)};
   assign upper     = merged[LEN_W-1:SECTOR_EXP];
   assign lowest    = upper & (~upper + UP_W'(1));

   always_comb begin
      low_pos = '0;
      for (int i = 0; i < UP_W; i++) begin
         if (lowest[i]) begin
            low_pos = low_pos | EXP_W'(i);
         end
      end
   end

   always_comb begin
      if (short_len || (merged[SECTOR_EXP-1:0] != '0)) begin
         aexp = EXP_W'(SECTOR_EXP);
      end else begin
         aexp = EXP_W'(SECTOR_EXP) + low_pos;
      end
   end

   assign align_val = LEN_W'(1) << aexp;
   assign pass      = (align_filter_ff == '0) || (align_filter_ff == align_val);

   // granularity and alignment bins, each saturated to its last bin
   assign gran_raw = req_length >> req_block_shift;

   always_comb begin
      if (gran_raw > LEN_W'(GRAN_BINS - 1)) begin
         gbin_rec = GBIN_MAX_W'(GRAN_BINS - 1);
      end else begin
         gbin_rec = GBIN_MAX_W'(gran_raw);
      end
      if (32'(aexp) > 32'(ALIGN_BINS - 1)) begin
         abin_rec = ABIN_MAX_W'(ALIGN_BINS - 1);
      end else begin
         abin_rec = ABIN_MAX_W'(aexp);
      end
   end

   assign cell_ok = req_histogram_select ? (32'(req_bin) < 32'(ALIGN_BINS))
                                         : (32'(req_bin) < 32'(GRAN_BINS));

   always_comb begin
      q_cmd          = '0;
      q_cmd.op       = op;
      q_cmd.hsel     = req_histogram_select;
      q_cmd.disk_idx = DIDX_MAX_W'(req_disk);
      q_cmd.aexp     = aexp;
      q_cmd.shift    = req_block_shift;
      q_cmd.cell_ok  = cell_ok;
      unique case (op)
         OP_RECORD: begin
            q_cmd.hit  = disk_ok && pass;
            q_cmd.gbin = gbin_rec;
            q_cmd.abin = abin_rec;
         end
         OP_READ, OP_CLEAR: begin
            q_cmd.hit  = disk_ok;
            q_cmd.gbin = GBIN_MAX_W'(req_bin);
            q_cmd.abin = ABIN_MAX_W'(req_bin);
         end
         default: begin
            q_cmd.hit  = 1'b0;
         end
      endcase
   end

   assign req_ready = !q_full && !clearing;
   assign q_push    = req_valid && req_ready;

endmodule

// ===== rtl/core/iah_queue.sv =====
// iah_queue: short fifo of classified items between front and back
// depends on iah_pkg

module iah_queue
   import iah_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    empty,
   output logic    full
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign empty   = (cnt_ff == '0);
   assign full    = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/core/iah_back.sv =====
// iah_back: counter memories, clearing pass, read-modify-write sequencer, result register
// depends on iah_pkg and iah_ram

module iah_back
   import iah_pkg::*;
#(
   parameter int NUM_DISKS  = DEF_NUM_DISKS,
   parameter int GRAN_BINS  = DEF_GRAN_BINS,
   parameter int ALIGN_BINS = DEF_ALIGN_BINS
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            q_head,
   input  logic               q_empty,
   output logic               q_pop,
   output logic               clearing,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_counted,
   output logic [EXP_W-1:0]   rsp_alignment_exp,
   output logic [BIN_W-1:0]   rsp_gran_bin,
   output logic [EXP_W-1:0]   rsp_align_bin,
   output logic [COUNT_W-1:0] rsp_count,
   output logic [SHIFT_W-1:0] rsp_recorded_shift
);

   localparam int DK_W  = (NUM_DISKS > 1) ? $clog2(NUM_DISKS) : 1;
   localparam int GB_W  = $clog2(GRAN_BINS);
   localparam int AB_W  = $clog2(ALIGN_BINS);
   localparam int GA_W  = DK_W + GB_W;
   localparam int AA_W  = DK_W + AB_W;
   localparam int CLR_W = (GA_W > AA_W) ? GA_W : AA_W;

   back_state_type state_ff, state_in;
   logic [CLR_W-1:0] clr_cnt_ff, clr_cnt_in;
   cmd_type          cmd_ff, cmd_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_counted_ff;
   logic [EXP_W-1:0]   rsp_aexp_ff;
   logic [BIN_W-1:0]   rsp_gbin_ff;
   logic [EXP_W-1:0]   rsp_abin_ff;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic [SHIFT_W-1:0] rsp_shift_ff;

   logic clr_done, out_free, commit;
   cmd_type sel;
   logic is_read, rec_hit, cell_hit, wipe;

   logic [GA_W-1:0]    gran_ra, gran_wa;
   logic [AA_W-1:0]    align_ra, align_wa;
   logic [DK_W-1:0]    shift_ra, shift_wa;
   logic [COUNT_W-1:0] gran_rd, align_rd, gran_wd, align_wd;
   logic [SHIFT_W-1:0] shift_rd, shift_wd;
   logic               gran_we, align_we, shift_we;

   assign clr_done = (clr_cnt_ff == {CLR_W{1'b1}});
   assign out_free = !rsp_valid_ff || rsp_ready;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_CLEAR: if (clr_done) state_in = BK_IDLE;
         BK_IDLE:  if (!q_empty) state_in = BK_EXEC;
         BK_EXEC:  if (out_free) state_in = BK_IDLE;
         default:  state_in = BK_CLEAR;
      endcase
   end

   // state outputs
   always_comb begin
      clearing = 1'b0;
      q_pop    = 1'b0;
      commit   = 1'b0;
      unique case (state_ff)
         BK_CLEAR: clearing = 1'b1;
         BK_IDLE:  q_pop    = !q_empty;
         BK_EXEC:  commit   = out_free;
         default:  clearing = 1'b0;
      endcase
   end

   assign clr_cnt_in = clearing ? clr_cnt_ff + CLR_W'(1) : clr_cnt_ff;
   assign cmd_in     = q_pop ? q_head : cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= BK_CLEAR;
         clr_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff <= cmd_in;
   end

   // read side: the popped item, or the one held while the result waits
   assign sel      = (state_ff == BK_EXEC) ? cmd_ff : q_head;
   assign gran_ra  = {sel.disk_idx[DK_W-1:0], sel.gbin[GB_W-1:0]};
   assign align_ra = {sel.disk_idx[DK_W-1:0], sel.abin[AB_W-1:0]};
   assign shift_ra = sel.disk_idx[DK_W-1:0];

   // write side
   assign is_read  = (cmd_ff.op == OP_READ) || (cmd_ff.op == OP_CLEAR);
   assign rec_hit  = (cmd_ff.op == OP_RECORD) && cmd_ff.hit;
   assign cell_hit = is_read && cmd_ff.hit && cmd_ff.cell_ok;
   assign wipe     = (cmd_ff.op == OP_CLEAR) && cell_hit;

   assign gran_we  = clearing || (commit && (rec_hit || (wipe && !cmd_ff.hsel)));
   assign align_we = clearing || (commit && (rec_hit || (wipe && cmd_ff.hsel)));
   assign shift_we = clearing || (commit && rec_hit);

   assign gran_wa  = clearing ? clr_cnt_ff[GA_W-1:0]
                              : {cmd_ff.disk_idx[DK_W-1:0], cmd_ff.gbin[GB_W-1:0]};
   assign align_wa = clearing ? clr_cnt_ff[AA_W-1:0]
                              : {cmd_ff.disk_idx[DK_W-1:0], cmd_ff.abin[AB_W-1:0]};
   assign shift_wa = clearing ? clr_cnt_ff[DK_W-1:0] : cmd_ff.disk_idx[DK_W-1:0];

   assign gran_wd  = (!clearing && rec_hit) ? gran_rd + COUNT_W'(1) : '0;
   assign align_wd = (!clearing && rec_hit) ? align_rd + COUNT_W'(1) : '0;
   assign shift_wd = clearing ? '0 : cmd_ff.shift;

   iah_ram #(.WIDTH(COUNT_W), .DEPTH(1 << GA_W)) u_gran_ram (
      .clock   (clock),
      .wr_en   (gran_we),
      .wr_addr (gran_wa),
      .wr_data (gran_wd),
      .rd_addr (gran_ra),
      .rd_data (gran_rd)
   );

   iah_ram #(.WIDTH(COUNT_W), .DEPTH(1 << AA_W)) u_align_ram (
      .clock   (clock),
      .wr_en   (align_we),
      .wr_addr (align_wa),
      .wr_data (align_wd),
      .rd_addr (align_ra),
      .rd_data (align_rd)
   );

   iah_ram #(.WIDTH(SHIFT_W), .DEPTH(1 << DK_W)) u_shift_ram (
      .clock   (clock),
      .wr_en   (shift_we),
      .wr_addr (shift_wa),
      .wr_data (shift_wd),
      .rd_addr (shift_ra),
      .rd_data (shift_rd)
   );

   // result register
   always_comb begin
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_counted_ff <= rec_hit;
         rsp_aexp_ff    <= (cmd_ff.op == OP_RECORD) ? cmd_ff.aexp : '0;
         rsp_gbin_ff    <= rec_hit ? BIN_W'(cmd_ff.gbin) : '0;
         rsp_abin_ff    <= rec_hit ? EXP_W'(cmd_ff.abin) : '0;
         rsp_count_ff   <= cell_hit ? (cmd_ff.hsel ? align_rd : gran_rd) : '0;
         rsp_shift_ff   <= (is_read && cmd_ff.hit) ? shift_rd : '0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_counted        = rsp_counted_ff;
   assign rsp_alignment_exp  = rsp_aexp_ff;
   assign rsp_gran_bin       = rsp_gbin_ff;
   assign rsp_align_bin      = rsp_abin_ff;
   assign rsp_count          = rsp_count_ff;
   assign rsp_recorded_shift = rsp_shift_ff;

endmodule
